### hw/rtl/ppr_pkg.sv
// Shared widths, register indexes and payload types of the Pauli pair rotation core.
package ppr_pkg;

   localparam int INDEX_BITS     = 20;
   localparam int PAIR_BITS      = INDEX_BITS - 1;
   localparam int AMP_BITS       = 16;
   localparam int FRAC_BITS      = AMP_BITS - 1;
   localparam int POS_BITS       = 5;
   localparam int PROD_BITS      = 2 * AMP_BITS + 1;
   localparam int SUM_BITS       = PROD_BITS + 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = INDEX_BITS;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = 1;
   localparam int QCNT_BITS      = 2;
   localparam int LATENCY        = 5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROTATION_KIND   = 3'd0,
      CSR_FLIP_MASK       = 3'd1,
      CSR_PHASE_MASK      = 3'd2,
      CSR_INSERT_POSITION = 3'd3,
      CSR_COS_COEF        = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [PAIR_BITS-1:0]       pair_index;
      logic signed [AMP_BITS-1:0] sin_coef;
      logic signed [AMP_BITS-1:0] left_real;
      logic signed [AMP_BITS-1:0] left_imag;
      logic signed [AMP_BITS-1:0] right_real;
      logic signed [AMP_BITS-1:0] right_imag;
      logic                       last_in;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]      left_addr;
      logic [INDEX_BITS-1:0]      right_addr;
      logic signed [AMP_BITS-1:0] new_left_real;
      logic signed [AMP_BITS-1:0] new_left_imag;
      logic signed [AMP_BITS-1:0] new_right_real;
      logic signed [AMP_BITS-1:0] new_right_imag;
      logic                       last_out;
   } rsp_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]      left_addr;
      logic [INDEX_BITS-1:0]      right_addr;
      logic signed [AMP_BITS-1:0] cos_coef;
      logic signed [AMP_BITS:0]   sin_coef;
      logic                       real_mode;
      logic signed [AMP_BITS-1:0] left_real;
      logic signed [AMP_BITS-1:0] left_imag;
      logic signed [AMP_BITS-1:0] right_real;
      logic signed [AMP_BITS-1:0] right_imag;
      logic                       last;
   } work_type;

endpackage

### hw/rtl/ppr_front.sv
// Front end: control registers, item intake, address and sign preparation.
module ppr_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  ppr_pkg::req_type                      req_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ppr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ppr_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                  queue_full,
   output logic                                  push,
   output ppr_pkg::work_type                     push_data
);

   localparam int IB = ppr_pkg::INDEX_BITS;
   localparam int AB = ppr_pkg::AMP_BITS;

   logic                            kind_ff;
   logic [IB-1:0]                   flip_ff;
   logic [IB-1:0]                   phase_ff;
   logic [ppr_pkg::POS_BITS-1:0]    pos_ff;
   logic signed [AB-1:0]            cos_ff;

   logic                            valid_ff, valid_in;
   ppr_pkg::work_type               work_ff, work_in;

   logic                            accept;
   logic [IB-1:0]                   idx_ext;
   logic [IB-1:0]                   idx_up;
   logic [IB-1:0]                   keep_mask;
   logic [IB-1:0]                   left;
   logic                            odd;
   logic signed [AB:0]              q_ext;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= 1'b0;
         flip_ff  <= '0;
         phase_ff <= '0;
         pos_ff   <= '0;
         cos_ff   <= AB'((2 ** (AB - 1)) - 1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ppr_pkg::CSR_ROTATION_KIND:   kind_ff  <= csr_wdata[0];
            ppr_pkg::CSR_FLIP_MASK:       flip_ff  <= csr_wdata[IB-1:0];
            ppr_pkg::CSR_PHASE_MASK:      phase_ff <= csr_wdata[IB-1:0];
            ppr_pkg::CSR_INSERT_POSITION: pos_ff   <= csr_wdata[ppr_pkg::POS_BITS-1:0];
            ppr_pkg::CSR_COS_COEF:        cos_ff   <= csr_wdata[AB-1:0];
            default: ;
         endcase
      end
   end

   assign push   = valid_ff && !queue_full;
   assign busy   = valid_ff && queue_full;
   assign accept = start && !busy;

   always_comb begin
      idx_ext   = {1'b0, req_data.pair_index};
      keep_mask = (IB'(1) << pos_ff) - IB'(1);
      idx_up    = (idx_ext & ~keep_mask) << 1;
      left      = (idx_ext & keep_mask) | idx_up;
      odd       = ^(left & phase_ff);
      q_ext     = (AB + 1)'(req_data.sin_coef);
      if (kind_ff && odd) begin
         q_ext = -q_ext;
      end

      work_in.left_addr  = left;
      work_in.right_addr = left ^ flip_ff;
      work_in.cos_coef   = cos_ff;
      work_in.sin_coef   = q_ext;
      work_in.real_mode  = kind_ff;
      work_in.left_real  = req_data.left_real;
      work_in.left_imag  = req_data.left_imag;
      work_in.right_real = req_data.right_real;
      work_in.right_imag = req_data.right_imag;
      work_in.last       = req_data.last_in;

      valid_in = accept || (valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         work_ff <= work_in;
      end
   end

   assign push_data = work_ff;

endmodule

### hw/rtl/ppr_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
module ppr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ppr_pkg::work_type push_data,
   output logic              full,
   output logic              pop_valid,
   output ppr_pkg::work_type pop_data
);

   ppr_pkg::work_type                 entry_ff [ppr_pkg::QUEUE_DEPTH];
   logic [ppr_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ppr_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ppr_pkg::QCNT_BITS-1:0]     count_ff, count_in;
   logic                              pop;

   assign full      = (count_ff == ppr_pkg::QCNT_BITS'(ppr_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + ppr_pkg::QPTR_BITS'(push);
      rd_ptr_in = rd_ptr_ff + ppr_pkg::QPTR_BITS'(pop);
      count_in  = count_ff + ppr_pkg::QCNT_BITS'(push) - ppr_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/ppr_back.sv
// Back end: product, sum and round-saturate pipeline that drives the result port.
module ppr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  ppr_pkg::work_type item,
   output logic              rsp_valid,
   output ppr_pkg::rsp_type  rsp_data
);

   localparam int IB = ppr_pkg::INDEX_BITS;
   localparam int AB = ppr_pkg::AMP_BITS;
   localparam int FB = ppr_pkg::FRAC_BITS;
   localparam int PB = ppr_pkg::PROD_BITS;
   localparam int SB = ppr_pkg::SUM_BITS;
   localparam logic signed [SB-1:0] SAT_HI   = SB'((2 ** (AB - 1)) - 1);
   localparam logic signed [SB-1:0] SAT_LO   = -SAT_HI - SB'(1);
   localparam logic signed [SB-1:0] ROUND_HF = SB'(2 ** (FB - 1));

   logic signed [AB-1:0] own_amp   [4];
   logic signed [AB-1:0] cross_amp [4];
   logic [3:0]           neg;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [PB-1:0] pc_ff [4], pc_in [4];
   logic signed [PB-1:0] pq_ff [4], pq_in [4];
   logic [3:0]           neg_ff;
   logic signed [SB-1:0] sum_ff [4], sum_in [4];
   logic signed [AB-1:0] res_in [4];
   logic [IB-1:0]        s1_left_ff, s1_right_ff, s2_left_ff, s2_right_ff;
   logic                 s1_last_ff, s2_last_ff;
   ppr_pkg::rsp_type     rsp_ff;

   always_comb begin
      own_amp[0] = item.left_real;
      own_amp[1] = item.left_imag;
      own_amp[2] = item.right_real;
      own_amp[3] = item.right_imag;
      if (item.real_mode) begin
         cross_amp[0] = item.right_real;
         cross_amp[1] = item.right_imag;
         cross_amp[2] = item.left_real;
         cross_amp[3] = item.left_imag;
         neg          = 4'b0011;
      end else begin
         cross_amp[0] = item.right_imag;
         cross_amp[1] = item.right_real;
         cross_amp[2] = item.left_imag;
         cross_amp[3] = item.left_real;
         neg          = 4'b0101;
      end
      for (int k = 0; k < 4; k++) begin
         pc_in[k] = PB'(item.cos_coef) * PB'(own_amp[k]);
         pq_in[k] = PB'(item.sin_coef) * PB'(cross_amp[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (neg_ff[k]) begin
            sum_in[k] = SB'(pc_ff[k]) - SB'(pq_ff[k]);
         end else begin
            sum_in[k] = SB'(pc_ff[k]) + SB'(pq_ff[k]);
         end
      end
   end

   always_comb begin
      logic signed [SB-1:0] t;
      t = '0;
      for (int k = 0; k < 4; k++) begin
         t = (sum_ff[k] + ROUND_HF) >>> FB;
         if (t > SAT_HI) begin
            t = SAT_HI;
         end else if (t < SAT_LO) begin
            t = SAT_LO;
         end
         res_in[k] = t[AB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= item_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         pc_ff[k]  <= pc_in[k];
         pq_ff[k]  <= pq_in[k];
         sum_ff[k] <= sum_in[k];
      end
      neg_ff      <= neg;
      s1_left_ff  <= item.left_addr;
      s1_right_ff <= item.right_addr;
      s1_last_ff  <= item.last;
      s2_left_ff  <= s1_left_ff;
      s2_right_ff <= s1_right_ff;
      s2_last_ff  <= s1_last_ff;
      rsp_ff.left_addr      <= s2_left_ff;
      rsp_ff.right_addr     <= s2_right_ff;
      rsp_ff.new_left_real  <= res_in[0];
      rsp_ff.new_left_imag  <= res_in[1];
      rsp_ff.new_right_real <= res_in[2];
      rsp_ff.new_right_imag <= res_in[3];
      rsp_ff.last_out       <= s2_last_ff;
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/pauli_pair_rotation_core.sv
// Top level of the Pauli pair rotation core: front end, queue and arithmetic back end.
//
// Usage:
//   Input: drive req_data and raise start; the item transfers at a rising edge
//   with start high and busy low. One item can transfer every cycle while busy is low.
//   Result: one result per item, shown on rsp_data for one cycle with rsp_valid
//   high, in input order. The receiver cannot hold results off.
//   Path: each item passes the front register, queue entry, product, sum and
//   round/saturate registers before its result is shown on rsp_data.
//   Throughput: one item per cycle; the back-end stages pop the queue whenever
//   it holds an entry, so busy stays low in normal operation.
//   Control registers: written through csr_valid/csr_ready with csr_index and
//   csr_wdata, by the user only while no item is in flight (not enforced);
//   csr_ready is always high. Indexes beyond the register list are ignored.
//   Reset: synchronous and active high; it empties the pipeline and queue,
//   drops any result in flight and loads the register defaults (cosine
//   coefficient at its largest positive value, all else zero).
module pauli_pair_rotation_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  ppr_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   output ppr_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ppr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic              push;
   ppr_pkg::work_type push_data;
   logic              queue_full;
   logic              pop_valid;
   ppr_pkg::work_type pop_data;

   ppr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   ppr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   ppr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, ppr_pkg::LATENCY))
      else $error("result without a matching input transfer");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_out == $past(req_data.last_in, ppr_pkg::LATENCY)))
      else $error("last mark out of order");

   a_never_stalls: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !busy)
      else $error("front end stalled although the back end drains every cycle");

endmodule
